@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the table's checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define ASSERT_RUN(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("size table port assertion failed");

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("size table reset assertion failed");

`endif

@@ hdl/slpt_pkg.sv @@
// ----------------------------------------------------------------------------
// Size table package
// Constants, codes and types shared by the pointer-to-size table.
// ----------------------------------------------------------------------------
package slpt_pkg;

    localparam int NUM_SHARDS_DEF  = 16;
    localparam int SHARD_SLOTS_DEF = 1024;
    localparam int PROBE_LIMIT_DEF = 64;

    localparam int KEY_W  = 64;
    localparam int SIZE_W = 48;
    localparam int HALF_W = 32;

    localparam logic [KEY_W-1:0] MIX_C1   = 64'hbf58476d1ce4e5b9;
    localparam logic [KEY_W-1:0] MIX_C2   = 64'h94d049bb133111eb;
    localparam int               MIX_S1   = 30;
    localparam int               MIX_S2   = 27;
    localparam int               MIX_S3   = 31;
    localparam logic [KEY_W-1:0] TOMB_KEY = '1;

    localparam int MOD_BITS    = 4;
    localparam int MOD_STEPS   = KEY_W / MOD_BITS;
    localparam int SHARD_STEPS = HALF_W / MOD_BITS;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_ABSENT  = 2'd1,
        ST_FULL    = 2'd2,
        ST_IGNORED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_MOD,
        S_PROBE,
        S_DONE
    } t_state;

endpackage

@@ hdl/slpt_ram.sv @@
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module slpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/sharded_linear_probe_size_table_top.sv @@
// ----------------------------------------------------------------------------
// Sharded linear-probe size table
// Maps 64-bit keys to 48-bit sizes by open addressing with tombstones.
// ----------------------------------------------------------------------------
// Each request is accepted, hashed on one 32x32 multiplier, then the shard
// and home remainder are formed at 4 bits per cycle, the probes follow at
// one key memory read per cycle, and a result state hands out the answer.
// Ignored requests go straight to the result state. One request is in flight
// at a time. After reset the key memory is cleared one slot per cycle, and no
// beat is accepted until all NUM_SHARDS*SHARD_SLOTS slots are clear.
module sharded_linear_probe_size_table_top import slpt_pkg::*; #(
    parameter int NUM_SHARDS  = NUM_SHARDS_DEF,
    parameter int SHARD_SLOTS = SHARD_SLOTS_DEF,
    parameter int PROBE_LIMIT = PROBE_LIMIT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_kind,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [SIZE_W-1:0] i_size_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [SIZE_W-1:0] o_size_out,
    output logic [1:0]        o_status
);

    localparam int TOTAL  = NUM_SHARDS * SHARD_SLOTS;
    localparam int AW     = $clog2(TOTAL);
    localparam int SHW    = (NUM_SHARDS > 1) ? $clog2(NUM_SHARDS) : 1;
    localparam int OFW    = $clog2(SHARD_SLOTS);
    localparam int PCW    = $clog2(PROBE_LIMIT + 1);
    localparam int MOD_CW = $clog2(MOD_STEPS);

    function automatic logic [SHW-1:0] shard_step(logic [SHW-1:0] r, logic b);
        logic [SHW:0] t;
        t = {r, b};
        if (t >= (SHW+1)'(NUM_SHARDS)) begin
            t = t - (SHW+1)'(NUM_SHARDS);
        end
        return t[SHW-1:0];
    endfunction

    function automatic logic [OFW-1:0] home_step(logic [OFW-1:0] r, logic b);
        logic [OFW:0] t;
        t = {r, b};
        if (t >= (OFW+1)'(SHARD_SLOTS)) begin
            t = t - (OFW+1)'(SHARD_SLOTS);
        end
        return t[OFW-1:0];
    endfunction

    t_state r_state, n_state;

    logic              r_o_valid, n_o_valid;
    logic [SIZE_W-1:0] r_o_size, n_o_size;
    t_status           r_o_status, n_o_status;
    logic [AW-1:0]     r_clr, n_clr;
    logic [1:0]        r_mstep, n_mstep;
    logic              r_round, n_round;
    logic [MOD_CW-1:0] r_mcnt, n_mcnt;
    logic [PCW-1:0]    r_issue, n_issue;
    logic              r_rd_vld, n_rd_vld;

    logic [1:0]        r_kind, n_kind;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [KEY_W-1:0]  r_x, n_x;
    logic [KEY_W-1:0]  r_acc, n_acc;
    logic [KEY_W-1:0]  r_sh, n_sh;
    logic [SHW-1:0]    r_shard, n_shard;
    logic [OFW-1:0]    r_off, n_off;
    logic [AW-1:0]     r_rd_addr, n_rd_addr;
    logic [SIZE_W-1:0] r_res_size, n_res_size;
    t_status           r_res_status, n_res_status;

    logic [HALF_W-1:0] mul_a, mul_b;
    logic [KEY_W-1:0]  mul_p, mix_cst, mix_sum;
    logic              in_fire, out_free, ignored, clr_last, hash_last, mod_last;
    logic [AW-1:0]     probe_addr;
    logic [KEY_W-1:0]  key_rdata;
    logic [SIZE_W-1:0] size_rdata;
    logic              probe_last, k_hit, k_empty, k_tomb;
    logic              ev_stop;
    t_status           ev_status;
    logic [SIZE_W-1:0] ev_size;
    logic              key_we, size_we;
    logic [AW-1:0]     key_waddr;
    logic [KEY_W-1:0]  key_wdata;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_size_out  = r_o_size;
    assign o_status    = r_o_status;

    assign in_fire   = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_o_valid || i_out_ready;
    assign ignored   = (i_key == '0) || (i_key == TOMB_KEY) || (i_kind == KIND_UNUSED)
                       || ((i_kind == KIND_INSERT) && (i_size_in == '0));
    assign clr_last  = (r_clr == AW'(TOTAL - 1));
    assign hash_last = r_round && (r_mstep == 2'd2);
    assign mod_last  = (r_mcnt == MOD_CW'(MOD_STEPS - 1));

    assign mix_cst = r_round ? MIX_C2 : MIX_C1;
    assign mul_a   = (r_mstep == 2'd2) ? r_x[KEY_W-1:HALF_W] : r_x[HALF_W-1:0];
    assign mul_b   = (r_mstep == 2'd1) ? mix_cst[KEY_W-1:HALF_W] : mix_cst[HALF_W-1:0];
    assign mul_p   = mul_a * mul_b;
    assign mix_sum = r_acc + {mul_p[HALF_W-1:0], {HALF_W{1'b0}}};

    assign probe_addr = AW'(r_shard) * AW'(SHARD_SLOTS) + AW'(r_off);
    assign probe_last = (r_issue == PCW'(PROBE_LIMIT));
    assign k_hit      = (key_rdata == r_key);
    assign k_empty    = (key_rdata == '0);
    assign k_tomb     = (key_rdata == TOMB_KEY);

    always_comb begin
        ev_stop   = 1'b0;
        ev_status = ST_ABSENT;
        ev_size   = '0;
        key_we    = 1'b0;
        size_we   = 1'b0;
        key_waddr = r_rd_addr;
        key_wdata = r_key;
        if (r_state == S_CLEAR) begin
            key_we    = 1'b1;
            key_waddr = r_clr;
            key_wdata = '0;
        end else if (r_state == S_PROBE && r_rd_vld) begin
            case (r_kind)
                KIND_INSERT: begin
                    if (k_empty || k_tomb || k_hit) begin
                        ev_stop   = 1'b1;
                        ev_status = ST_DONE;
                        key_we    = 1'b1;
                        size_we   = 1'b1;
                    end else if (probe_last) begin
                        ev_stop   = 1'b1;
                        ev_status = ST_FULL;
                    end
                end
                KIND_LOOKUP: begin
                    if (k_hit) begin
                        ev_stop   = 1'b1;
                        ev_status = ST_DONE;
                        ev_size   = size_rdata;
                    end else if (k_empty || probe_last) begin
                        ev_stop   = 1'b1;
                    end
                end
                KIND_REMOVE: begin
                    if (k_hit) begin
                        ev_stop   = 1'b1;
                        ev_status = ST_DONE;
                        key_we    = 1'b1;
                        key_wdata = TOMB_KEY;
                    end else if (k_empty || probe_last) begin
                        ev_stop   = 1'b1;
                    end
                end
                default: begin
                    ev_stop   = 1'b1;
                    ev_status = ST_IGNORED;
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = ignored ? S_DONE : S_HASH;
            end
            S_HASH: begin
                if (hash_last) n_state = S_MOD;
            end
            S_MOD: begin
                if (mod_last) n_state = S_PROBE;
            end
            S_PROBE: begin
                if (ev_stop) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        logic [SHW-1:0] rs;
        logic [OFW-1:0] rh;
        n_o_valid    = r_o_valid && !i_out_ready;
        n_o_size     = r_o_size;
        n_o_status   = r_o_status;
        n_clr        = r_clr;
        n_mstep      = r_mstep;
        n_round      = r_round;
        n_mcnt       = r_mcnt;
        n_issue      = r_issue;
        n_rd_vld     = 1'b0;
        n_kind       = r_kind;
        n_key        = r_key;
        n_size       = r_size;
        n_x          = r_x;
        n_acc        = r_acc;
        n_sh         = r_sh;
        n_shard      = r_shard;
        n_off        = r_off;
        n_rd_addr    = r_rd_addr;
        n_res_size   = r_res_size;
        n_res_status = r_res_status;
        rs           = r_shard;
        rh           = r_off;
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + AW'(1);
            end
            S_IDLE: begin
                if (in_fire) begin
                    n_kind       = i_kind;
                    n_key        = i_key;
                    n_size       = i_size_in;
                    n_x          = i_key ^ (i_key >> MIX_S1);
                    n_mstep      = 2'd0;
                    n_round      = 1'b0;
                    n_res_size   = '0;
                    n_res_status = ST_IGNORED;
                end
            end
            S_HASH: begin
                n_acc   = (r_mstep == 2'd0) ? mul_p : mix_sum;
                n_mstep = r_mstep + 2'd1;
                if (r_mstep == 2'd2) begin
                    n_mstep = 2'd0;
                    n_round = 1'b1;
                    n_x     = mix_sum ^ (mix_sum >> MIX_S2);
                    if (r_round) begin
                        n_sh    = mix_sum ^ (mix_sum >> MIX_S3);
                        n_mcnt  = '0;
                        n_shard = '0;
                        n_off   = '0;
                    end
                end
            end
            S_MOD: begin
                for (int j = 0; j < MOD_BITS; j++) begin
                    if (r_mcnt < MOD_CW'(SHARD_STEPS)) begin
                        rs = shard_step(rs, r_sh[KEY_W-1-j]);
                    end
                    rh = home_step(rh, r_sh[KEY_W-1-j]);
                end
                n_shard = rs;
                n_off   = rh;
                n_sh    = r_sh << MOD_BITS;
                n_mcnt  = r_mcnt + MOD_CW'(1);
                n_issue = '0;
            end
            S_PROBE: begin
                if (!probe_last && !ev_stop) begin
                    n_rd_vld  = 1'b1;
                    n_rd_addr = probe_addr;
                    n_issue   = r_issue + PCW'(1);
                    n_off     = (r_off == OFW'(SHARD_SLOTS - 1)) ? '0 : r_off + OFW'(1);
                end
                if (ev_stop) begin
                    n_res_size   = ev_size;
                    n_res_status = ev_status;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_size   = r_res_size;
                    n_o_status = r_res_status;
                end
            end
            default: begin
                n_rd_vld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_o_valid <= 1'b0;
            r_clr     <= '0;
            r_mstep   <= '0;
            r_round   <= 1'b0;
            r_mcnt    <= '0;
            r_issue   <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_clr     <= n_clr;
            r_mstep   <= n_mstep;
            r_round   <= n_round;
            r_mcnt    <= n_mcnt;
            r_issue   <= n_issue;
            r_rd_vld  <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_size     <= n_o_size;
        r_o_status   <= n_o_status;
        r_kind       <= n_kind;
        r_key        <= n_key;
        r_size       <= n_size;
        r_x          <= n_x;
        r_acc        <= n_acc;
        r_sh         <= n_sh;
        r_shard      <= n_shard;
        r_off        <= n_off;
        r_rd_addr    <= n_rd_addr;
        r_res_size   <= n_res_size;
        r_res_status <= n_res_status;
    end

    slpt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TOTAL)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (key_wdata),
        .i_raddr (probe_addr),
        .o_rdata (key_rdata)
    );

    slpt_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (TOTAL)
    ) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (size_we),
        .i_waddr (r_rd_addr),
        .i_wdata (r_size),
        .i_raddr (probe_addr),
        .o_rdata (size_rdata)
    );

endmodule

@@ hdl/slpt_checker.sv @@
// ----------------------------------------------------------------------------
// Size table checker
// Port-level assertions on the size table, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slpt_checker import slpt_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [SIZE_W-1:0] o_size_out,
    input logic [1:0]        o_status
);

    `ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_in_ready)
    `ASSERT_RUN(a_one_in_flight, i_clk, i_rst_n,
        (i_in_valid && o_in_ready) |=> !o_in_ready)
    `ASSERT_RUN(a_size_only_done, i_clk, i_rst_n,
        (o_out_valid && o_status != ST_DONE) |-> (o_size_out == '0))
    `ASSERT_RUN(a_out_holds, i_clk, i_rst_n,
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_size_out) && $stable(o_status)))

endmodule

bind sharded_linear_probe_size_table_top slpt_checker u_slpt_checker (.*);
